FILE: rtl/core/tsmq_pkg.sv
// Shared types and codes for the two-sided match queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsmq_pkg;

  localparam int ID_W  = 16;
  localparam int CNT_W = 3;

  typedef logic [1:0] outcome_t;

  localparam outcome_t OUTCOME_MATCHED  = 2'd0;
  localparam outcome_t OUTCOME_QUEUED   = 2'd1;
  localparam outcome_t OUTCOME_REJECTED = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/two_sided_match_queue.sv
// Two-sided arrival matching with one waiting ring per side.
// Both rings share one synchronous memory; depends on tsmq_pkg.
//
// Each arriving item either takes the oldest waiting entry of the other side
// (matched), is appended to its own side's ring (queued), or is turned away
// when that ring already holds SLOTS-1 entries (rejected). The result of a
// queued or rejected item sits in the output register at the next edge; a
// matched item first reads the partner id from the ring memory into the read
// register and waits in ST_READ until the output register is free. A new item
// is taken in ST_IDLE while the previous result waits, as long as the output
// register is drained in the same cycle. Ring contents have no reset; only the
// head and tail pointers, the state and the output valid flag are cleared.
`timescale 1ns / 1ps
`default_nettype none

module two_sided_match_queue #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_side,
  input  wire logic [tsmq_pkg::ID_W-1:0] in_person_id,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tsmq_pkg::outcome_t             out_outcome,
  output logic [tsmq_pkg::ID_W-1:0]      out_partner_id,
  output logic [tsmq_pkg::CNT_W-1:0]     out_waiting_first,
  output logic [tsmq_pkg::CNT_W-1:0]     out_waiting_second
);

  import tsmq_pkg::*;

  localparam int PW    = $clog2(SLOTS);
  localparam int AW    = PW + 1;
  localparam int DEPTH = 2 * (2 ** PW);
  localparam int SW    = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
    return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_count(input logic [PW-1:0] h,
                                               input logic [PW-1:0] t);
    logic [PW:0] d;
    if (t >= h) begin
      d = {1'b0, t} - {1'b0, h};
    end else begin
      d = {1'b0, t} + AW'(SLOTS) - {1'b0, h};
    end
    return d[PW-1:0];
  endfunction

  state_t st_r, st_nxt;

  logic [PW-1:0] hd0_r, tl0_r, hd1_r, tl1_r;
  logic [PW-1:0] hd0_nxt, tl0_nxt, hd1_nxt, tl1_nxt;

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          out_valid_r, out_valid_nxt;
  outcome_t      outcome_r, outcome_nxt;
  logic [ID_W-1:0]  partner_r, partner_nxt;
  logic [CNT_W-1:0] wf_r, wf_nxt, ws_r, ws_nxt;

  logic          in_acc;
  logic          out_free;
  logic          ld_now;
  outcome_t      ld_outcome;
  logic          ld_match;
  logic [PW-1:0] own_hd, own_tl, oth_hd, oth_tl, new_ptr;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign own_hd  = in_side ? hd1_r : hd0_r;
  assign own_tl  = in_side ? tl1_r : tl0_r;
  assign oth_hd  = in_side ? hd0_r : hd1_r;
  assign oth_tl  = in_side ? tl0_r : tl1_r;

  always_comb begin
    st_nxt     = st_r;
    hd0_nxt    = hd0_r;
    tl0_nxt    = tl0_r;
    hd1_nxt    = hd1_r;
    tl1_nxt    = tl1_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    ld_now     = 1'b0;
    ld_outcome = OUTCOME_REJECTED;
    ld_match   = 1'b0;
    new_ptr    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (oth_hd != oth_tl) begin
            new_ptr = wrap_next(oth_hd);
            if (in_side) begin
              hd0_nxt = new_ptr;
            end else begin
              hd1_nxt = new_ptr;
            end
            rd_en   = 1'b1;
            rd_addr = {~in_side, new_ptr};
            st_nxt  = ST_READ;
          end else if (wrap_next(own_tl) == own_hd) begin
            ld_now     = 1'b1;
            ld_outcome = OUTCOME_REJECTED;
          end else begin
            new_ptr = wrap_next(own_tl);
            if (in_side) begin
              tl1_nxt = new_ptr;
            end else begin
              tl0_nxt = new_ptr;
            end
            wr_en      = 1'b1;
            wr_addr    = {in_side, new_ptr};
            ld_now     = 1'b1;
            ld_outcome = OUTCOME_QUEUED;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          ld_match = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    outcome_nxt   = outcome_r;
    partner_nxt   = partner_r;
    wf_nxt        = wf_r;
    ws_nxt        = ws_r;
    if (ld_now || ld_match) begin
      out_valid_nxt = 1'b1;
      outcome_nxt   = ld_match ? OUTCOME_MATCHED : ld_outcome;
      partner_nxt   = ld_match ? ID_W'(rd_data_r) : '0;
      wf_nxt        = CNT_W'(ring_count(hd0_nxt, tl0_nxt));
      ws_nxt        = CNT_W'(ring_count(hd1_nxt, tl1_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_person_id[SW-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      hd0_r       <= '0;
      tl0_r       <= '0;
      hd1_r       <= '0;
      tl1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      hd0_r       <= hd0_nxt;
      tl0_r       <= tl0_nxt;
      hd1_r       <= hd1_nxt;
      tl1_r       <= tl1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    partner_r <= partner_nxt;
    wf_r      <= wf_nxt;
    ws_r      <= ws_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_partner_id     = partner_r;
  assign out_waiting_first  = wf_r;
  assign out_waiting_second = ws_r;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for two_sided_match_queue: directed and random arrivals on both sides,
// with random idling on both channels, a long output hold-off and a drain pause.
// Depends on tsmq_pkg and the two_sided_match_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import tsmq_pkg::*;

  localparam int SLOTS        = 8;
  localparam int ARRIVALS     = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 20;

  typedef struct packed {
    outcome_t           outcome;
    logic [ID_W-1:0]    partner_id;
    logic [CNT_W-1:0]   waiting_first;
    logic [CNT_W-1:0]   waiting_second;
  } match_result_t;

  class match_scoreboard;
    logic [ID_W-1:0] wait_ring [2][SLOTS];
    int              head_ptr [2];
    int              tail_ptr [2];
    match_result_t   due_q [$];
    int              errors;

    function new();
      head_ptr = '{0, 0};
      tail_ptr = '{0, 0};
      errors   = 0;
    endfunction

    function int waiting(int s);
      return (tail_ptr[s] - head_ptr[s] + SLOTS) % SLOTS;
    endfunction

    function void note_arrival(logic side, logic [ID_W-1:0] person);
      int             own;
      int             other;
      match_result_t  res;
      own   = int'(side);
      other = 1 - own;
      res   = '0;
      if (head_ptr[other] != tail_ptr[other]) begin
        head_ptr[other] = (head_ptr[other] + 1) % SLOTS;
        res.partner_id  = wait_ring[other][head_ptr[other]];
        res.outcome     = OUTCOME_MATCHED;
      end else if ((tail_ptr[own] + 1) % SLOTS == head_ptr[own]) begin
        res.outcome = OUTCOME_REJECTED;
      end else begin
        tail_ptr[own]                 = (tail_ptr[own] + 1) % SLOTS;
        wait_ring[own][tail_ptr[own]] = person;
        res.outcome                   = OUTCOME_QUEUED;
      end
      res.waiting_first  = CNT_W'(waiting(0));
      res.waiting_second = CNT_W'(waiting(1));
      due_q.push_back(res);
    endfunction

    function void check_result(match_result_t got);
      match_result_t want;
      if (due_q.size() == 0) begin
        $error("unexpected result: outcome %0d partner_id %0h", got.outcome, got.partner_id);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
        errors++;
      end
      if (got.partner_id !== want.partner_id) begin
        $error("partner_id: expected %0h, got %0h", want.partner_id, got.partner_id);
        errors++;
      end
      if (got.waiting_first !== want.waiting_first) begin
        $error("waiting_first: expected %0d, got %0d", want.waiting_first, got.waiting_first);
        errors++;
      end
      if (got.waiting_second !== want.waiting_second) begin
        $error("waiting_second: expected %0d, got %0d", want.waiting_second,
               got.waiting_second);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_side;
  logic [ID_W-1:0]   in_person_id;
  logic              out_valid;
  logic              out_ready;
  outcome_t          out_outcome;
  logic [ID_W-1:0]   out_partner_id;
  logic [CNT_W-1:0]  out_waiting_first;
  logic [CNT_W-1:0]  out_waiting_second;

  match_scoreboard   sb;
  int                cycle_count = 0;
  int                arrivals_sent = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;
  bit                hold_req = 1'b0;

  two_sided_match_queue u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_side            (in_side),
    .in_person_id       (in_person_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_partner_id     (out_partner_id),
    .out_waiting_first  (out_waiting_first),
    .out_waiting_second (out_waiting_second)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_arrival(logic side, logic [ID_W-1:0] person);
    in_valid     <= 1'b1;
    in_side      <= side;
    in_person_id <= person;
    do @(posedge clk); while (!in_ready);
    sb.note_arrival(side, person);
    arrivals_sent++;
  endtask

  task automatic sender_idle();
    int n;
    n = tx_steady ? 0 : idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_and_idle(logic side, logic [ID_W-1:0] person);
    send_arrival(side, person);
    sender_idle();
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [ID_W-1:0] ids [7];
    ids = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001, 16'h7FFE};
    send_and_idle(1'b0, 16'h0000);
    send_and_idle(1'b1, 16'hFFFF);
    foreach (ids[i]) send_and_idle(1'b0, ids[i]);
    send_and_idle(1'b0, 16'h1234);
    foreach (ids[i]) send_and_idle(1'b1, ~ids[i]);
    foreach (ids[i]) send_and_idle(1'b1, ids[i] ^ 16'h0F0F);
    send_and_idle(1'b1, 16'hFFFF);
  endtask

  task automatic run_random();
    int  burst;
    bit  side;
    bit  pressure_done;
    bit  pause_done;
    pressure_done = 1'b0;
    pause_done    = 1'b0;
    while (arrivals_sent < ARRIVALS) begin
      if (!pressure_done && arrivals_sent >= 600) begin
        pressure_done = 1'b1;
        hold_req      = 1'b1;
        tx_steady     = 1'b1;
        repeat (30) send_arrival(1'($urandom_range(0, 1)), ID_W'($urandom));
        tx_steady     = 1'b0;
      end
      if (!pause_done && arrivals_sent >= 1200) begin
        pause_done = 1'b1;
        drain_pause();
      end
      if ((arrivals_sent / 100) % 4 == 3) tx_steady = 1'b1;
      else tx_steady = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        send_and_idle(1'($urandom_range(0, 1)), ID_W'($urandom));
      end else begin
        side  = 1'($urandom_range(0, 1));
        burst = $urandom_range(1, 10);
        repeat (burst) send_and_idle(side, ID_W'($urandom));
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (cycle_count % 256 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HOLD_CYCLES;
          hold_req   = 1'b0;
        end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
          stall_left = idle_len() + 1;
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        sb.check_result('{out_outcome, out_partner_id, out_waiting_first,
                          out_waiting_second});
    end
  end

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_side      <= 1'b0;
    in_person_id <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    drain_pause();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
